FILE: hdl/s5hs_pkg.sv
package s5hs_pkg;

    localparam int DATA_W  = 64;
    localparam int BYTES_W = 4;
    localparam int IDX_W   = 9;

    typedef enum logic [3:0] {
        PH_GVER   = 4'd0,
        PH_GNUM   = 4'd1,
        PH_GMETH  = 4'd2,
        PH_RVER   = 4'd3,
        PH_RCMD   = 4'd4,
        PH_RRSV   = 4'd5,
        PH_RATYP  = 4'd6,
        PH_RFIFTH = 4'd7,
        PH_NAME   = 4'd8,
        PH_PHI    = 4'd9,
        PH_PLO    = 4'd10,
        PH_WAIT   = 4'd11,
        PH_FWD    = 4'd12,
        PH_CLOSED = 4'd13,
        PH_SKIP   = 4'd14
    } phase_t;

    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_OUTCOME = 2'd1;
    localparam logic [1:0] FUNC_RESET   = 2'd2;

    localparam logic [2:0] KIND_REPLY   = 3'd0;
    localparam logic [2:0] KIND_ADDR    = 3'd1;
    localparam logic [2:0] KIND_PORT    = 3'd2;
    localparam logic [2:0] KIND_FWD     = 3'd3;
    localparam logic [2:0] KIND_CLOSE   = 3'd4;
    localparam logic [2:0] KIND_REFUSED = 3'd5;

    localparam logic [1:0] AK_NONE   = 2'd0;
    localparam logic [1:0] AK_IPV4   = 2'd1;
    localparam logic [1:0] AK_IPV6   = 2'd2;
    localparam logic [1:0] AK_DOMAIN = 2'd3;

    localparam logic [7:0] SOCKS_VER    = 8'h05;
    localparam logic [7:0] METHOD_NONE  = 8'h00;
    localparam logic [7:0] CMD_CONNECT  = 8'h01;
    localparam logic [7:0] ATYP_IPV4    = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
    localparam logic [7:0] ATYP_IPV6    = 8'h04;
    localparam logic [7:0] REP_SUCCESS  = 8'h00;
    localparam logic [7:0] RSV_BYTE     = 8'h00;
    localparam logic [7:0] SKIP_IPV4    = 8'd5;
    localparam logic [7:0] SKIP_IPV6    = 8'd17;
    localparam logic [IDX_W-1:0] REPLY_HDR   = 9'd5;
    localparam logic [IDX_W-1:0] REPLY_FIXED = 9'd7;

    typedef struct packed {
        logic                valid;
        logic [2:0]          kind;
        logic [DATA_W-1:0]   data;
        logic [BYTES_W-1:0]  bytes;
        logic                last;
    } result_t;

endpackage

FILE: hdl/socks5_handshake_parser.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------------
// s_       | s_valid / s_ready  | s_func, s_data_byte, s_connect_ok
// m_       | m_valid / m_ready  | m_out_kind, m_out_data, m_out_bytes, m_out_last
//
// An accepted client byte or event gives at most one result, held in the output
// register. A successful connect outcome starts the reply walk: the first byte goes
// to a pending register, then one reply byte per cycle while the output takes each
// result; name bytes use the registered read port. s_ready stays low until the last
// reply result is loaded. aresetn is synchronous; the name store is not cleared.
// A held result with m_ready low stalls both the reply walk and input acceptance.
module socks5_handshake_parser #(
    parameter int NAME_DEPTH       = 256,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_connect_ok,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_out_kind,
    output logic [s5hs_pkg::DATA_W-1:0]    m_out_data,
    output logic [s5hs_pkg::BYTES_W-1:0]   m_out_bytes,
    output logic                           m_out_last
);
    import s5hs_pkg::*;

    localparam int AW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

    phase_t               phase_reg, phase_next;
    logic [7:0]           byte_count_reg, byte_count_next;
    logic                 method_found_reg, method_found_next;
    logic [1:0]           address_kind_reg, address_kind_next;
    logic [7:0]           name_length_reg, name_length_next;
    logic [15:0]          dest_port_reg, dest_port_next;

    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           kind_reg, kind_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic                 last_reg, last_next;

    logic                 out_free;
    logic                 accept;
    result_t              pres;
    result_t              rres;
    logic                 reply_start;
    logic                 reply_busy;
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    logic [7:0]           bc_dec;
    logic [7:0]           bc_inc;
    logic                 mf_upd;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !reply_busy && out_free;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_GVER;
            byte_count_reg   <= '0;
            method_found_reg <= 1'b0;
            address_kind_reg <= AK_NONE;
            name_length_reg  <= '0;
            dest_port_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            method_found_reg <= method_found_next;
            address_kind_reg <= address_kind_next;
            name_length_reg  <= name_length_next;
            dest_port_reg    <= dest_port_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        bytes_reg <= bytes_next;
        last_reg  <= last_next;
    end

    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        method_found_next = method_found_reg;
        address_kind_next = address_kind_reg;
        name_length_next  = name_length_reg;
        dest_port_next    = dest_port_reg;
        pres.valid        = 1'b0;
        pres.kind         = KIND_CLOSE;
        pres.data         = '0;
        pres.bytes        = BYTES_W'(1);
        pres.last         = 1'b1;
        reply_start       = 1'b0;
        wr_en             = 1'b0;
        bc_dec            = byte_count_reg - 1'b1;
        bc_inc            = byte_count_reg + 1'b1;
        mf_upd            = method_found_reg || (s_data_byte == METHOD_NONE);

        if (accept) begin
            case (s_func)
                FUNC_BYTE: begin
                    case (phase_reg)
                        PH_GVER: begin
                            if (s_data_byte != SOCKS_VER) begin
                                phase_next = PH_CLOSED;
                                pres.valid = 1'b1;
                            end else begin
                                phase_next = PH_GNUM;
                            end
                        end
                        PH_GNUM: begin
                            if (s_data_byte == 8'd0) begin
                                phase_next = PH_CLOSED;
                                pres.valid = 1'b1;
                            end else begin
                                byte_count_next   = s_data_byte;
                                method_found_next = 1'b0;
                                phase_next        = PH_GMETH;
                            end
                        end
                        PH_GMETH: begin
                            method_found_next = mf_upd;
                            byte_count_next   = bc_dec;
                            if (bc_dec == 8'd0) begin
                                pres.valid = 1'b1;
                                if (!mf_upd) begin
                                    phase_next = PH_CLOSED;
                                end else begin
                                    phase_next = PH_RVER;
                                    pres.kind  = KIND_REPLY;
                                    pres.data  = DATA_W'({SOCKS_VER, METHOD_NONE});
                                    pres.bytes = BYTES_W'(2);
                                end
                            end
                        end
                        PH_RVER: phase_next = PH_RCMD;
                        PH_RCMD: begin
                            method_found_next = (s_data_byte == CMD_CONNECT);
                            phase_next        = PH_RRSV;
                        end
                        PH_RRSV: phase_next = PH_RATYP;
                        PH_RATYP: begin
                            if (s_data_byte == ATYP_IPV4) begin
                                address_kind_next = AK_IPV4;
                            end else if (s_data_byte == ATYP_IPV6) begin
                                address_kind_next = AK_IPV6;
                            end else if (s_data_byte == ATYP_DOMAIN) begin
                                address_kind_next = AK_DOMAIN;
                            end else begin
                                address_kind_next = AK_NONE;
                            end
                            phase_next = PH_RFIFTH;
                        end
                        PH_RFIFTH: begin
                            if (!method_found_reg || address_kind_reg == AK_NONE) begin
                                phase_next = PH_CLOSED;
                                pres.valid = 1'b1;
                            end else if (address_kind_reg != AK_DOMAIN) begin
                                byte_count_next = (address_kind_reg == AK_IPV4) ?
                                                  SKIP_IPV4 : SKIP_IPV6;
                                phase_next      = PH_SKIP;
                            end else if ({1'b0, s_data_byte} > 9'(NAME_DEPTH)) begin
                                phase_next = PH_CLOSED;
                                pres.valid = 1'b1;
                            end else begin
                                name_length_next = s_data_byte;
                                byte_count_next  = '0;
                                phase_next = (s_data_byte == 8'd0) ? PH_PHI : PH_NAME;
                            end
                        end
                        PH_SKIP: begin
                            byte_count_next = bc_dec;
                            if (bc_dec == 8'd0) begin
                                phase_next = PH_CLOSED;
                                pres.valid = 1'b1;
                            end
                        end
                        PH_NAME: begin
                            wr_en           = 1'b1;
                            byte_count_next = bc_inc;
                            if (bc_inc >= name_length_reg) begin
                                phase_next = PH_PHI;
                            end
                            pres.valid = 1'b1;
                            pres.kind  = KIND_ADDR;
                            pres.data  = DATA_W'(s_data_byte);
                        end
                        PH_PHI: begin
                            dest_port_next = {s_data_byte, 8'h00};
                            phase_next     = PH_PLO;
                        end
                        PH_PLO: begin
                            dest_port_next = {dest_port_reg[15:8], s_data_byte};
                            phase_next     = PH_WAIT;
                            pres.valid     = 1'b1;
                            pres.kind      = KIND_PORT;
                            pres.data      = DATA_W'({dest_port_reg[15:8], s_data_byte});
                            pres.bytes     = BYTES_W'(2);
                        end
                        PH_WAIT: ;
                        PH_FWD: begin
                            pres.valid = 1'b1;
                            pres.kind  = KIND_FWD;
                            pres.data  = DATA_W'(s_data_byte);
                        end
                        default: begin
                            pres.valid = 1'b1;
                            pres.kind  = KIND_REFUSED;
                            pres.data  = DATA_W'(s_data_byte);
                        end
                    endcase
                end
                FUNC_OUTCOME: begin
                    if (phase_reg == PH_WAIT) begin
                        if (s_connect_ok) begin
                            phase_next  = PH_FWD;
                            reply_start = 1'b1;
                        end else begin
                            phase_next = PH_CLOSED;
                            pres.valid = 1'b1;
                        end
                    end
                end
                FUNC_RESET: begin
                    phase_next        = PH_GVER;
                    byte_count_next   = '0;
                    method_found_next = 1'b0;
                    address_kind_next = AK_NONE;
                    name_length_next  = '0;
                    dest_port_next    = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        data_next    = data_reg;
        bytes_next   = bytes_reg;
        last_next    = last_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_free && pres.valid) begin
            m_valid_next = 1'b1;
            kind_next    = pres.kind;
            data_next    = pres.data;
            bytes_next   = pres.bytes;
            last_next    = pres.last;
        end else if (out_free && rres.valid) begin
            m_valid_next = 1'b1;
            kind_next    = rres.kind;
            data_next    = rres.data;
            bytes_next   = rres.bytes;
            last_next    = rres.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_kind  = kind_reg;
    assign m_out_data  = data_reg;
    assign m_out_bytes = bytes_reg;
    assign m_out_last  = last_reg;

    s5hs_name_mem #(
        .DEPTH(NAME_DEPTH),
        .AW   (AW)
    ) u_name_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(byte_count_reg[AW-1:0]),
        .wr_data(s_data_byte),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    s5hs_reply_gen #(
        .AW              (AW),
        .BYTES_PER_RESULT(BYTES_PER_RESULT)
    ) u_reply_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (reply_start),
        .name_length(name_length_reg),
        .dest_port  (dest_port_reg),
        .res_ready  (out_free),
        .res        (rres),
        .busy       (reply_busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

endmodule

FILE: hdl/s5hs_name_mem.sv
module s5hs_name_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/s5hs_reply_gen.sv
module s5hs_reply_gen #(
    parameter int AW               = 8,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [7:0]            name_length,
    input  logic [15:0]           dest_port,
    input  logic                  res_ready,
    output s5hs_pkg::result_t     res,
    output logic                  busy,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  logic [7:0]            rd_data
);
    import s5hs_pkg::*;

    logic                 busy_reg, busy_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     total_reg, total_next;
    logic                 pv_reg, pv_next;
    logic [7:0]           const_reg, const_next;
    logic                 is_name_reg, is_name_next;
    logic                 last_reg, last_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [BYTES_W-1:0]   cnt_reg, cnt_next;

    logic [IDX_W-1:0]     len_ext;
    logic [IDX_W-1:0]     name_off;
    logic [7:0]           cur_byte;
    logic [DATA_W-1:0]    acc_shift;
    logic [BYTES_W-1:0]   cnt_inc;
    logic                 emit;
    logic                 consume;
    logic                 issue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pv_reg   <= pv_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        const_reg   <= const_next;
        is_name_reg <= is_name_next;
        last_reg    <= last_next;
    end

    always_comb begin
        len_ext   = {1'b0, name_length};
        name_off  = idx_reg - REPLY_HDR;
        cur_byte  = is_name_reg ? rd_data : const_reg;
        acc_shift = {acc_reg[DATA_W-9:0], cur_byte};
        cnt_inc   = cnt_reg + 1'b1;
        emit      = pv_reg && ((cnt_inc == BYTES_W'(BYTES_PER_RESULT)) || last_reg);
        consume   = pv_reg && (!emit || res_ready);
        issue     = busy_reg && (idx_reg < total_reg) && (!pv_reg || consume);

        rd_en   = issue;
        rd_addr = name_off[AW-1:0];

        busy_next    = busy_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        pv_next      = pv_reg;
        const_next   = const_reg;
        is_name_next = is_name_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;

        if (start) begin
            busy_next  = 1'b1;
            idx_next   = '0;
            total_next = REPLY_FIXED + len_ext;
            pv_next    = 1'b0;
            acc_next   = '0;
            cnt_next   = '0;
        end else begin
            if (consume) begin
                pv_next = 1'b0;
                if (emit) begin
                    acc_next = '0;
                    cnt_next = '0;
                end else begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                end
                if (last_reg) begin
                    busy_next = 1'b0;
                end
            end
            if (issue) begin
                pv_next      = 1'b1;
                idx_next     = idx_reg + 1'b1;
                last_next    = (idx_reg == total_reg - 1'b1);
                is_name_next = 1'b0;
                if (idx_reg == 9'd0) begin
                    const_next = SOCKS_VER;
                end else if (idx_reg == 9'd1) begin
                    const_next = REP_SUCCESS;
                end else if (idx_reg == 9'd2) begin
                    const_next = RSV_BYTE;
                end else if (idx_reg == 9'd3) begin
                    const_next = ATYP_DOMAIN;
                end else if (idx_reg == 9'd4) begin
                    const_next = name_length;
                end else if (idx_reg < REPLY_HDR + len_ext) begin
                    const_next   = 8'h00;
                    is_name_next = 1'b1;
                end else if (idx_reg == REPLY_HDR + len_ext) begin
                    const_next = dest_port[15:8];
                end else begin
                    const_next = dest_port[7:0];
                end
            end
        end

        res.valid = emit;
        res.kind  = KIND_REPLY;
        res.data  = acc_shift;
        res.bytes = cnt_inc;
        res.last  = last_reg;
        busy      = busy_reg;
    end

endmodule
